/* rtl/core/point_rigid_transform_assert.svh */
// ----------------------------------------------------------------------------
// point_rigid_transform assertion macros
// Short forms for the concurrent checks of the point transform core.
// Each macro expects signals named clk and rst in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef POINT_RIGID_TRANSFORM_ASSERT_SVH
`define POINT_RIGID_TRANSFORM_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PRT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/prt_pkg.sv */
// ----------------------------------------------------------------------------
// prt_pkg
// Shared types and register map of the point rigid transform core.
// ----------------------------------------------------------------------------
package prt_pkg;

  // quaternion components are always 32 bits wide
  localparam int QUAT_W  = 32;
  localparam int COLOR_W = 8;
  localparam int NUM_REGS = 7;

  typedef logic [2:0] reg_idx_t;

  // register map, index order
  localparam reg_idx_t REG_QUAT_X  = 3'd0;
  localparam reg_idx_t REG_QUAT_Y  = 3'd1;
  localparam reg_idx_t REG_QUAT_Z  = 3'd2;
  localparam reg_idx_t REG_QUAT_W  = 3'd3;
  localparam reg_idx_t REG_SHIFT_X = 3'd4;
  localparam reg_idx_t REG_SHIFT_Y = 3'd5;
  localparam reg_idx_t REG_SHIFT_Z = 3'd6;

  typedef logic signed [QUAT_W-1:0] entry_t;

  typedef struct packed {
    entry_t x;
    entry_t y;
    entry_t z;
    entry_t w;
  } quat_t;

  // row-major 3x3 rotation matrix
  typedef entry_t [8:0] mat_t;

  // matrix builder status
  typedef struct packed {
    logic busy;
  } mat_status_t;

endpackage

/* rtl/core/prt_matrix.sv */
// ----------------------------------------------------------------------------
// prt_matrix
// Builds the rotation matrix from the quaternion registers in two register
// stages: nine component products, then rounded and saturated entries.
// ----------------------------------------------------------------------------
module prt_matrix #(
  parameter int QUAT_FRAC_BITS = 30
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  prt_pkg::quat_t        quat,
  output prt_pkg::mat_t         mat,
  output prt_pkg::mat_status_t  status
);

  localparam int ProdW = 2 * prt_pkg::QUAT_W;
  localparam int SumW  = ProdW + 2;
  localparam logic [1:0] BuildCycles = 2'd2;

  localparam logic signed [SumW-1:0] One2     = SumW'(1) <<< (2 * QUAT_FRAC_BITS - 1);
  localparam logic signed [SumW-1:0] HalfLsb  = SumW'(1) <<< (QUAT_FRAC_BITS - 2);
  localparam logic signed [SumW-1:0] EntryMax = {{(SumW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SumW-1:0] EntryMin = {{(SumW-31){1'b1}}, {31{1'b0}}};

  logic signed [ProdW-1:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
  logic [1:0] build_cnt;

  // round half up to the entry scale and clamp to 32 bits
  function automatic prt_pkg::entry_t round_sat(input logic signed [SumW-1:0] acc);
    logic signed [SumW-1:0] scaled;
    scaled = (acc + HalfLsb) >>> (QUAT_FRAC_BITS - 1);
    if (scaled > EntryMax) begin
      return prt_pkg::entry_t'(EntryMax[prt_pkg::QUAT_W-1:0]);
    end else if (scaled < EntryMin) begin
      return prt_pkg::entry_t'(EntryMin[prt_pkg::QUAT_W-1:0]);
    end
    return prt_pkg::entry_t'(scaled[prt_pkg::QUAT_W-1:0]);
  endfunction

  // product stage
  always_ff @(posedge clk) begin
    xx <= quat.x * quat.x;
    yy <= quat.y * quat.y;
    zz <= quat.z * quat.z;
    xy <= quat.x * quat.y;
    xz <= quat.x * quat.z;
    yz <= quat.y * quat.z;
    xw <= quat.x * quat.w;
    yw <= quat.y * quat.w;
    zw <= quat.z * quat.w;
  end

  // entry stage
  always_ff @(posedge clk) begin
    mat[0] <= round_sat(One2 - SumW'(yy) - SumW'(zz));
    mat[1] <= round_sat(SumW'(xy) - SumW'(zw));
    mat[2] <= round_sat(SumW'(xz) + SumW'(yw));
    mat[3] <= round_sat(SumW'(xy) + SumW'(zw));
    mat[4] <= round_sat(One2 - SumW'(xx) - SumW'(zz));
    mat[5] <= round_sat(SumW'(yz) - SumW'(xw));
    mat[6] <= round_sat(SumW'(xz) - SumW'(yw));
    mat[7] <= round_sat(SumW'(yz) + SumW'(xw));
    mat[8] <= round_sat(One2 - SumW'(xx) - SumW'(yy));
  end

  // rebuild counter, restarted by reset and by every register write
  always_ff @(posedge clk) begin
    if (rst || load) begin
      build_cnt <= BuildCycles;
    end else if (build_cnt != 2'd0) begin
      build_cnt <= build_cnt - 2'd1;
    end
  end

  assign status.busy = (build_cnt != 2'd0);

endmodule

/* rtl/core/point_rigid_transform.sv */
// ----------------------------------------------------------------------------
// point_rigid_transform
// Rotates each point by a quaternion matrix and adds a translation.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one point per beat: pos_x, pos_y, pos_z (signed Q16.16)
//   and the red, green and blue bytes in tdata, end of cloud in tlast.
//   m_axis returns one beat per point: out_x, out_y, out_z and the colors in
//   tdata, end of cloud in tlast, and in tuser a flag set when any coordinate
//   saturated.
//   The APB port holds quat_x/y/z/w (Q2.30) and shift_x/y/z (Q16.16).
// Timing:
//   four register stages (input, products, row sums, saturation): a result
//   passes them in order and is valid on m_axis from the saturation stage.
//   One point per cycle is sustained unless m_axis_tready or a rebuild stalls.
// Reset and writes:
//   reset loads the identity rotation and zero translation. After reset and
//   every register write s_axis_tready stays low while the matrix is rebuilt.
//   The user must write registers only when the core is idle; it is not enforced.
// Stalls:
//   a low m_axis_tready holds the output beat; stages behind it fill empty
//   slots, so tready drops only in a rebuild or once every stage holds a beat.
// ----------------------------------------------------------------------------
`include "point_rigid_transform_assert.svh"

module point_rigid_transform #(
  parameter int COORD_BITS     = 32,
  parameter int QUAT_FRAC_BITS = 30,
  localparam int RegBytes = (COORD_BITS > 32) ? 8 : 4,
  localparam int DataW    = RegBytes * 8,
  localparam int AddrW    = $clog2(RegBytes * prt_pkg::NUM_REGS),
  localparam int TdataW   = ((3 * COORD_BITS + 3 * prt_pkg::COLOR_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  // pos_x, pos_y, pos_z, red_in, green_in, blue_in from the lowest bit up
  input  logic [TdataW-1:0] s_axis_tdata,
  input  logic              s_axis_tlast,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // out_x, out_y, out_z, red_out, green_out, blue_out from the lowest bit up
  output logic [TdataW-1:0] m_axis_tdata,
  // clipped
  output logic              m_axis_tuser,
  output logic              m_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  localparam int C       = COORD_BITS;
  localparam int ColW    = 3 * prt_pkg::COLOR_W;
  localparam int AddrLsb = $clog2(RegBytes);
  localparam int ProdW   = prt_pkg::QUAT_W + C;
  localparam int SumW    = ProdW + 2;
  localparam int VW      = SumW + 1;

  localparam logic signed [SumW-1:0] RowRound = SumW'(1) <<< (QUAT_FRAC_BITS - 1);
  localparam logic signed [VW-1:0] CoordMax = {{(VW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [VW-1:0] CoordMin = {{(VW-C+1){1'b1}}, {(C-1){1'b0}}};
  localparam logic signed [C-1:0] OutMax = {1'b0, {(C-1){1'b1}}};
  localparam logic signed [C-1:0] OutMin = {1'b1, {(C-1){1'b0}}};

  // configuration registers
  prt_pkg::quat_t       quat;
  logic signed [C-1:0]  shift [3];
  prt_pkg::reg_idx_t    reg_idx;
  logic                 cfg_wr;

  prt_pkg::mat_t        mat;
  prt_pkg::mat_status_t mat_status;

  // pipeline registers
  logic                    v1, v2, v3, v4;
  logic                    rdy1, rdy2, rdy3, rdy4;
  logic signed [C-1:0]     p1 [3];
  logic signed [ProdW-1:0] prod [3][3];
  logic signed [VW-1:0]    sum3 [3];
  logic signed [C-1:0]     out4 [3];
  logic signed [VW-1:0]    sum3_next [3];
  logic signed [C-1:0]     out4_next [3];
  logic                    clip4_next;
  logic                    clip4;
  logic [ColW-1:0]         col1, col2, col3, col4;
  logic                    last1, last2, last3, last4;
  logic                    out_sat;

  // ---------------------------------------------------------------- apb
  assign pready  = 1'b1;
  assign reg_idx = prt_pkg::reg_idx_t'(paddr[AddrW-1:AddrLsb]);
  assign cfg_wr  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      quat.x   <= '0;
      quat.y   <= '0;
      quat.z   <= '0;
      quat.w   <= prt_pkg::entry_t'(64'd1 << QUAT_FRAC_BITS);
      shift[0] <= '0;
      shift[1] <= '0;
      shift[2] <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        prt_pkg::REG_QUAT_X:  quat.x   <= pwdata[prt_pkg::QUAT_W-1:0];
        prt_pkg::REG_QUAT_Y:  quat.y   <= pwdata[prt_pkg::QUAT_W-1:0];
        prt_pkg::REG_QUAT_Z:  quat.z   <= pwdata[prt_pkg::QUAT_W-1:0];
        prt_pkg::REG_QUAT_W:  quat.w   <= pwdata[prt_pkg::QUAT_W-1:0];
        prt_pkg::REG_SHIFT_X: shift[0] <= pwdata[C-1:0];
        prt_pkg::REG_SHIFT_Y: shift[1] <= pwdata[C-1:0];
        prt_pkg::REG_SHIFT_Z: shift[2] <= pwdata[C-1:0];
        default: ;
      endcase
    end
  end

  // register reads, sign extended
  always_comb begin
    unique case (reg_idx)
      prt_pkg::REG_QUAT_X:  prdata = DataW'(quat.x);
      prt_pkg::REG_QUAT_Y:  prdata = DataW'(quat.y);
      prt_pkg::REG_QUAT_Z:  prdata = DataW'(quat.z);
      prt_pkg::REG_QUAT_W:  prdata = DataW'(quat.w);
      prt_pkg::REG_SHIFT_X: prdata = DataW'(shift[0]);
      prt_pkg::REG_SHIFT_Y: prdata = DataW'(shift[1]);
      prt_pkg::REG_SHIFT_Z: prdata = DataW'(shift[2]);
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- matrix
  prt_matrix #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_matrix (
    .clk    (clk),
    .rst    (rst),
    .load   (cfg_wr),
    .quat   (quat),
    .mat    (mat),
    .status (mat_status)
  );

  // ---------------------------------------------------------------- flow
  // a stage takes a beat when it is empty or its successor moves on
  assign rdy4 = !v4 || m_axis_tready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_axis_tready = rdy1 && !mat_status.busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid && s_axis_tready;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // stage 1: input beat
  always_ff @(posedge clk) begin
    if (rdy1) begin
      p1[0] <= s_axis_tdata[C-1:0];
      p1[1] <= s_axis_tdata[2*C-1:C];
      p1[2] <= s_axis_tdata[3*C-1:2*C];
      col1  <= s_axis_tdata[3*C+ColW-1:3*C];
      last1 <= s_axis_tlast;
    end
  end

  // stage 2: matrix times point, one product per entry
  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= $signed(mat[3*r+c]) * p1[c];
        end
      end
      col2  <= col1;
      last2 <= last1;
    end
  end

  // stage 3: row sums, rounded to point scale, plus translation
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum3_next[r] = VW'((SumW'(prod[r][0]) + SumW'(prod[r][1]) + SumW'(prod[r][2])
                          + RowRound) >>> QUAT_FRAC_BITS) + VW'(shift[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      sum3  <= sum3_next;
      col3  <= col2;
      last3 <= last2;
    end
  end

  // stage 4: saturation to the coordinate range
  always_comb begin
    clip4_next = 1'b0;
    for (int r = 0; r < 3; r++) begin
      if (sum3[r] > CoordMax) begin
        out4_next[r] = OutMax;
        clip4_next   = 1'b1;
      end else if (sum3[r] < CoordMin) begin
        out4_next[r] = OutMin;
        clip4_next   = 1'b1;
      end else begin
        out4_next[r] = sum3[r][C-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      out4  <= out4_next;
      clip4 <= clip4_next;
      col4  <= col3;
      last4 <= last3;
    end
  end

  // output beat
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[C-1:0]           = out4[0];
    m_axis_tdata[2*C-1:C]         = out4[1];
    m_axis_tdata[3*C-1:2*C]       = out4[2];
    m_axis_tdata[3*C+ColW-1:3*C]  = col4;
  end

  assign m_axis_tuser  = clip4;
  assign m_axis_tlast  = last4;
  assign m_axis_tvalid = v4;

  // ---------------------------------------------------------------- checks
  // some output coordinate sits at a range limit
  assign out_sat = (out4[0] == OutMax) || (out4[0] == OutMin) ||
                   (out4[1] == OutMax) || (out4[1] == OutMin) ||
                   (out4[2] == OutMax) || (out4[2] == OutMin);

  `PRT_ASSERT_NEXT(a_write_holds_input, cfg_wr, !s_axis_tready, "input taken during matrix rebuild")
  `PRT_ASSERT_NEXT(a_accept_fills_stage, s_axis_tvalid && s_axis_tready, v1, "accepted beat lost at entry")
  `PRT_ASSERT_SAME(a_clip_at_limit, m_axis_tvalid && m_axis_tuser, out_sat, "clip without saturation")

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: point_rigid_transform testbench
// Streams points through the core under several rotation and translation
// settings, predicts each beat from the register copy kept here unless a
// directed row gives it, and compares it field by field. A directed table
// runs first, random traffic with random stalls on both stream sides follows.
// ----------------------------------------------------------------------------
module tb;

  localparam int QF = 30;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES = 8;
  localparam int PHASE_POINTS = 100;
  localparam prt_pkg::reg_idx_t REG_UNUSED = 3'd7;

  localparam logic signed [127:0] MAX32 = 128'sd2147483647;
  localparam logic signed [127:0] MIN32 = -128'sd2147483648;
  localparam logic signed [127:0] ONE2 = 128'sd1 <<< (2 * QF - 1);
  localparam logic signed [127:0] HALF_ENTRY = 128'sd1 <<< (QF - 2);
  localparam logic signed [127:0] HALF_ROW = 128'sd1 <<< (QF - 1);

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } point_in_t;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
    logic        clip;
  } point_out_t;

  // one row of the directed table: a register write or a point
  typedef struct packed {
    logic              is_write;
    prt_pkg::reg_idx_t idx;
    logic [31:0]       val;
    point_in_t         pt;
    logic              typed;
    point_out_t        want;
  } plan_row_t;

  logic         clk;
  logic         rst;
  logic [119:0] s_axis_tdata;  // pos_x, pos_y, pos_z, red_in, green_in, blue_in
  logic         s_axis_tlast;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [119:0] m_axis_tdata;  // out_x, out_y, out_z, red_out, green_out, blue_out
  logic         m_axis_tuser;  // clipped
  logic         m_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [4:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  // register copy used by the predictor
  logic signed [31:0] quat [4];
  logic signed [31:0] shift [3];

  point_out_t pending_points [$];
  plan_row_t  plan [$];
  logic       calm;
  int         fail_count;
  int         cycle_count;
  int         points_sent;
  int         reg_writes;
  int         clipped_seen;
  int         cloud_ends_seen;

  point_rigid_transform u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // saturate a wide value to the signed 32-bit range
  function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
    if (v > MAX32) return MAX32[31:0];
    if (v < MIN32) return MIN32[31:0];
    return v[31:0];
  endfunction

  // one matrix entry: round half up to QF fraction bits, then saturate
  function automatic logic signed [31:0] mat_term(logic signed [127:0] base,
                                                  logic signed [127:0] a,
                                                  logic signed [127:0] b);
    logic signed [127:0] total;
    total = base + a + b + HALF_ENTRY;
    return clamp32(total >>> (QF - 1));
  endfunction

  // rotate by the quaternion matrix, translate, saturate
  function automatic point_out_t transform_point(point_in_t p);
    logic signed [127:0] qx, qy, qz, qw;
    logic signed [127:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
    logic signed [127:0] m [9];
    logic signed [127:0] pv [3];
    logic signed [127:0] acc;
    logic signed [31:0]  coord [3];
    point_out_t r;
    int i;
    qx = 128'(quat[0]);
    qy = 128'(quat[1]);
    qz = 128'(quat[2]);
    qw = 128'(quat[3]);
    xx = qx * qx;
    yy = qy * qy;
    zz = qz * qz;
    xy = qx * qy;
    xz = qx * qz;
    yz = qy * qz;
    xw = qx * qw;
    yw = qy * qw;
    zw = qz * qw;
    m[0] = 128'(mat_term(ONE2, -yy, -zz));
    m[1] = 128'(mat_term(128'sd0, xy, -zw));
    m[2] = 128'(mat_term(128'sd0, xz, yw));
    m[3] = 128'(mat_term(128'sd0, xy, zw));
    m[4] = 128'(mat_term(ONE2, -xx, -zz));
    m[5] = 128'(mat_term(128'sd0, yz, -xw));
    m[6] = 128'(mat_term(128'sd0, xz, -yw));
    m[7] = 128'(mat_term(128'sd0, yz, xw));
    m[8] = 128'(mat_term(ONE2, -xx, -yy));
    pv[0] = 128'($signed(p.px));
    pv[1] = 128'($signed(p.py));
    pv[2] = 128'($signed(p.pz));
    r.clip = 1'b0;
    for (i = 0; i < 3; i++) begin
      acc = m[3*i] * pv[0] + m[3*i+1] * pv[1] + m[3*i+2] * pv[2];
      acc = ((acc + HALF_ROW) >>> QF) + shift[i];
      if (acc > MAX32 || acc < MIN32) r.clip = 1'b1;
      coord[i] = clamp32(acc);
    end
    r.px = coord[0];
    r.py = coord[1];
    r.pz = coord[2];
    r.red = p.red;
    r.green = p.green;
    r.blue = p.blue;
    r.last = p.last;
    return r;
  endfunction

  // directed table rows
  function automatic plan_row_t wr(prt_pkg::reg_idx_t idx, logic [31:0] val);
    plan_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic plan_row_t pt(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                   logic [7:0] rd, logic [7:0] gn, logic [7:0] bl,
                                   logic lst);
    plan_row_t r;
    r = '0;
    r.pt = '{px: x, py: y, pz: z, red: rd, green: gn, blue: bl, last: lst};
    return r;
  endfunction

  function automatic plan_row_t pt_typed(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                         logic [7:0] rd, logic [7:0] gn, logic [7:0] bl,
                                         logic lst, logic [31:0] ex, logic [31:0] ey,
                                         logic [31:0] ez, logic clp);
    plan_row_t r;
    r = pt(x, y, z, rd, gn, bl, lst);
    r.typed = 1'b1;
    r.want = '{px: ex, py: ey, pz: ez, red: rd, green: gn, blue: bl, last: lst, clip: clp};
    return r;
  endfunction

  function automatic int pause_len();
    if (calm) return 0;
    return $urandom_range(0, 5);
  endfunction

  // random coordinate: full range, within +/-128.0, or an extreme
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0, 1: return $urandom;
      2, 3: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic point_in_t rand_point();
    point_in_t p;
    p.px = rand_coord();
    p.py = rand_coord();
    p.pz = rand_coord();
    p.red = 8'($urandom);
    p.green = 8'($urandom);
    p.blue = 8'($urandom);
    p.last = ($urandom_range(0, 7) == 0);
    return p;
  endfunction

  // quaternion component by flavor: within -1.0 to 1.0, extreme, near identity
  function automatic logic [31:0] rand_quat(int mode, bit is_w);
    case (mode)
      0: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
      1: begin
        case ($urandom_range(0, 2))
          0: return 32'hC000_0000;
          1: return 32'h0000_0000;
          default: return 32'h4000_0000;
        endcase
      end
      default: begin
        if (is_w) return 32'h4000_0000 - $urandom_range(0, 32'h0100_0000);
        return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      end
    endcase
  endfunction

  function automatic logic [31:0] rand_shift(int mode);
    case (mode)
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 2))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  // lower valid and wait until every expected beat has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // register write, then a read back for mapped registers
  task automatic write_reg(prt_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    reg_writes++;
    if (idx <= prt_pkg::REG_QUAT_W) quat[idx[1:0]] = val;
    else if (idx <= prt_pkg::REG_SHIFT_Z) shift[2'(idx - prt_pkg::REG_SHIFT_X)] = val;
    @(negedge clk);
    if (idx <= prt_pkg::REG_SHIFT_Z) begin
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      check_field("prdata", val, prdata);
      @(negedge clk);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // new rotation and translation for one random phase
  task automatic new_setting(int phase);
    int i;
    for (i = 0; i < 4; i++) begin
      write_reg(prt_pkg::reg_idx_t'(i), rand_quat(phase % 3, i == 3));
    end
    for (i = 4; i < 7; i++) write_reg(prt_pkg::reg_idx_t'(i), rand_shift((phase + 1) % 3));
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);
  endtask

  // present one point, record its expected beat at acceptance
  task automatic send_point(point_in_t p, logic typed, point_out_t want, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata <= {p.blue, p.green, p.red, p.pz, p.py, p.px};
    s_axis_tlast <= p.last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_points.push_back(typed ? want : transform_point(p));
    points_sent++;
    @(negedge clk);
  endtask

  // output side: random stalls, compare each beat with the oldest expectation
  initial begin
    point_out_t got;
    point_out_t want;
    int stall;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = pause_len();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got.px = m_axis_tdata[31:0];
      got.py = m_axis_tdata[63:32];
      got.pz = m_axis_tdata[95:64];
      got.red = m_axis_tdata[103:96];
      got.green = m_axis_tdata[111:104];
      got.blue = m_axis_tdata[119:112];
      got.last = m_axis_tlast;
      got.clip = m_axis_tuser;
      if (pending_points.size() == 0) begin
        $error("output beat with no point outstanding");
        fail_count++;
      end else begin
        want = pending_points.pop_front();
        check_field("out_x", want.px, got.px);
        check_field("out_y", want.py, got.py);
        check_field("out_z", want.pz, got.pz);
        check_field("red_out", 32'(want.red), 32'(got.red));
        check_field("green_out", 32'(want.green), 32'(got.green));
        check_field("blue_out", 32'(want.blue), 32'(got.blue));
        check_field("cloud_end_out", 32'(want.last), 32'(got.last));
        check_field("clipped", 32'(want.clip), 32'(got.clip));
        if (got.clip === 1'b1) clipped_seen++;
        if (got.last === 1'b1) cloud_ends_seen++;
      end
      @(negedge clk);
    end
  end

  // main sequence
  initial begin
    plan_row_t row;
    int phase;
    int k;
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    points_sent = 0;
    reg_writes = 0;
    clipped_seen = 0;
    cloud_ends_seen = 0;
    quat[0] = 0;
    quat[1] = 0;
    quat[2] = 0;
    quat[3] = 32'h4000_0000;
    shift[0] = 0;
    shift[1] = 0;
    shift[2] = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity after reset: points come back unchanged
    plan.push_back(pt_typed(0, 0, 0, 8'h00, 8'h00, 8'h00, 1'b0, 0, 0, 0, 1'b0));
    plan.push_back(pt_typed(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            8'hFF, 8'hFF, 8'hFF, 1'b1,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    plan.push_back(pt_typed(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            8'hAA, 8'h55, 8'h0F, 1'b0,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
    plan.push_back(pt_typed(32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000,
                            8'h01, 8'h80, 8'hFE, 1'b1,
                            32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 1'b0));
    // write beyond the register map is dropped
    plan.push_back(wr(REG_UNUSED, 32'hDEAD_BEEF));
    plan.push_back(pt_typed(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
                            8'h33, 8'hCC, 8'h5A, 1'b0,
                            32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 1'b0));
    // extreme translation: exact reach of the limits, then overflow
    plan.push_back(wr(prt_pkg::REG_SHIFT_X, 32'h7FFF_FFFF));
    plan.push_back(wr(prt_pkg::REG_SHIFT_Y, 32'h8000_0000));
    plan.push_back(wr(prt_pkg::REG_SHIFT_Z, 32'h0000_0001));
    plan.push_back(pt_typed(0, 0, 0, 8'h11, 8'h22, 8'h33, 1'b0,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0));
    plan.push_back(pt_typed(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0005,
                            8'h44, 8'h55, 8'h66, 1'b1,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0006, 1'b1));
    plan.push_back(pt_typed(32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF,
                            8'h77, 8'h88, 8'h99, 1'b0,
                            32'h7FFF_FFFE, 32'h8000_0001, 32'h7FFF_FFFF, 1'b1));
    plan.push_back(wr(prt_pkg::REG_SHIFT_X, 0));
    plan.push_back(wr(prt_pkg::REG_SHIFT_Y, 0));
    plan.push_back(wr(prt_pkg::REG_SHIFT_Z, 0));
    // half turn about z negates x and y
    plan.push_back(wr(prt_pkg::REG_QUAT_Z, 32'h4000_0000));
    plan.push_back(wr(prt_pkg::REG_QUAT_W, 32'h0000_0000));
    plan.push_back(pt_typed(32'h0000_0005, 32'hFFFF_FFF9, 32'h0000_0009,
                            8'h10, 8'h20, 8'h30, 1'b0,
                            32'hFFFF_FFFB, 32'h0000_0007, 32'h0000_0009, 1'b0));
    plan.push_back(pt_typed(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                            8'h40, 8'h50, 8'h60, 1'b1,
                            32'h7FFF_FFFF, 32'h8000_0001, 32'h0000_0000, 1'b1));
    // quaternion not of unit length, used as given
    plan.push_back(wr(prt_pkg::REG_QUAT_W, 32'h4000_0000));
    plan.push_back(pt(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 8'h01, 8'h02, 8'h03, 1'b0));
    plan.push_back(pt(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'h04, 8'h05, 8'h06, 1'b1));
    // quarter turn about x
    plan.push_back(wr(prt_pkg::REG_QUAT_X, 32'h2D41_3CCD));
    plan.push_back(wr(prt_pkg::REG_QUAT_Z, 32'h0000_0000));
    plan.push_back(wr(prt_pkg::REG_QUAT_W, 32'h2D41_3CCD));
    plan.push_back(pt(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 8'h07, 8'h08, 8'h09, 1'b0));
    plan.push_back(pt(32'hFFFF_0000, 32'h7FFF_0000, 32'h8001_0000, 8'h0A, 8'h0B, 8'h0C, 1'b0));
    // all components at -1.0: matrix entries saturate
    plan.push_back(wr(prt_pkg::REG_QUAT_X, 32'hC000_0000));
    plan.push_back(wr(prt_pkg::REG_QUAT_Y, 32'hC000_0000));
    plan.push_back(wr(prt_pkg::REG_QUAT_Z, 32'hC000_0000));
    plan.push_back(wr(prt_pkg::REG_QUAT_W, 32'hC000_0000));
    plan.push_back(pt(32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000, 8'h0D, 8'h0E, 8'h0F, 1'b0));
    plan.push_back(pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hF0, 8'hE0, 8'hD0, 1'b1));
    plan.push_back(pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'hC0, 8'hB0, 8'hA0, 1'b0));

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_write) begin
        drain();
        write_reg(row.idx, row.val);
      end else begin
        send_point(row.pt, row.typed, row.want, pause_len());
      end
    end

    // random phases, each with its own setting and stall mode
    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      new_setting(phase);
      calm = ($urandom_range(0, 3) == 0);
      for (k = 0; k < PHASE_POINTS; k++) begin
        if (k == PHASE_POINTS / 2) drain();
        send_point(rand_point(), 1'b0, '0, pause_len());
      end
    end

    drain();
    repeat (10) @(posedge clk);

    $display("sent %0d points under %0d register writes across %0d random settings",
             points_sent, reg_writes, PHASES);
    $display("%0d output beats saturated, %0d marked end of cloud",
             clipped_seen, cloud_ends_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
